/* design/additive_sawtooth_oscillator_assert.svh */
// Assertion macros shared by the oscillator modules.
// No dependencies; each user file includes this header after its timescale line.
`ifndef ADDITIVE_SAWTOOTH_OSCILLATOR_ASSERT_SVH
`define ADDITIVE_SAWTOOTH_OSCILLATOR_ASSERT_SVH

`ifndef SYNTHESIS
// general property, checked while out of reset
`define ASO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("oscillator assertion failed");
// implication form, consequent checked in the same cycle
`define ASO_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oscillator implication failed");
`else
`define ASO_ASSERT(lbl, clk, rst_n, prop)
`define ASO_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/aso_pkg.sv */
// Package for the additive sawtooth oscillator: widths, fixed-point constants,
// controller states, command/status structs and the sine table generator.
// No dependencies.
`timescale 1ns / 1ps

package aso_pkg;

    // field and register widths
    localparam int PHASE_W    = 32;
    localparam int AMP_W      = 16;
    localparam int HC_W       = 10;
    localparam int OUT_W      = 24;
    localparam int ROT_W      = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [ROT_W-1:0] t_rot;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_PHASE_STEP = 2'd0;
    localparam t_cfg_idx CFG_AMPLITUDE  = 2'd1;
    localparam t_cfg_idx CFG_HARM_COUNT = 2'd2;

    // fixed-point constants
    localparam t_rot              ROT_ONE     = 19'sd131072;
    localparam logic signed [23:0] INV_PI_Q24 = 24'sd5340353;
    localparam logic [63:0]       Q30_ONE     = 64'd1073741824;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INDEX,
        S_ROM,
        S_RUN,
        S_DRAIN,
        S_ROUND,
        S_SCALE,
        S_PART,
        S_MERGE,
        S_SAT,
        S_PUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rom;
        logic step;
        logic round;
        logic scale;
        logic part;
        logic merge;
        logic sat;
        logic put;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic left_zero;
        logic pipe_empty;
        logic out_free;
    } t_sts;

    // taylor series for sin (odd) or cos (even) of a q30 angle below pi/2
    function automatic logic [63:0] series_q30(input logic [63:0] x, input logic odd);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2 = (x * x) >> 30;
        if (odd) begin
            term = x;
            sum  = $signed(term);
            term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        end else begin
            term = Q30_ONE;
            sum  = $signed(term);
            term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(Q30_ONE)) begin
            sum = $signed(Q30_ONE);
        end
        return sum;
    endfunction

    // sine of a 0.32 phase in q1.17, for building constant tables
    function automatic t_rot sine_q17(input logic [31:0] p);
        logic [63:0] x;
        logic [63:0] v;
        logic [63:0] r;
        x = ({34'd0, p[29:0]} * HALF_PI_Q30) >> 30;
        v = series_q30(x, !p[30]);
        r = (v + 64'd4096) >> 13;
        return p[31] ? -t_rot'(r) : t_rot'(r);
    endfunction

    // round a q34 product sum to q17 and clip to plus or minus one
    function automatic t_rot rot_round_sat(input logic signed [38:0] v);
        logic signed [38:0] t;
        t = (v + 39'sd65536) >>> 17;
        if (t > 39'sd131072) begin
            return ROT_ONE;
        end else if (t < -39'sd131072) begin
            return -ROT_ONE;
        end else begin
            return t_rot'(t);
        end
    endfunction

endpackage

/* design/additive_sawtooth_oscillator.sv */
// Top level of the additive sawtooth oscillator: configuration registers,
// sequencer and datapath.
// Depends on aso_pkg, aso_ctrl and aso_dp.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall | i_sample_tick
//  out     | output    | o_out_valid/i_out_stall | o_sample (signed 24 bit)
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A tick word passes through the sequencer steps from acceptance to a valid
// output word (harmonic count capped at MAX_HARMONICS), and the next word is
// taken once the sequencer is back in idle; the single rotation unit steps one
// harmonic per cycle. A word with sample_tick low is taken with no output.
// Reset loads the register defaults and zeroes the phase; no clearing pass.
// One finished word waits in the output register while the next sample is
// computed; the sequencer holds in its last step until that register frees.
`timescale 1ns / 1ps

module additive_sawtooth_oscillator #(
    parameter int MAX_HARMONICS    = 512,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_sample_tick,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [aso_pkg::OUT_W-1:0]    o_sample,
    input  logic                                i_cfg_we,
    input  logic [aso_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [aso_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import aso_pkg::*;

    logic [PHASE_W-1:0] r_phase_step;
    logic [AMP_W-1:0]   r_amplitude;
    logic [HC_W-1:0]    r_harmonic_count;

    t_cmd w_cmd;
    t_sts w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step     <= '0;
            r_amplitude      <= AMP_W'(32768);
            r_harmonic_count <= HC_W'(400);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_STEP: r_phase_step     <= i_cfg_data[PHASE_W-1:0];
                CFG_AMPLITUDE:  r_amplitude      <= i_cfg_data[AMP_W-1:0];
                CFG_HARM_COUNT: r_harmonic_count <= i_cfg_data[HC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    aso_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_sample_tick (i_sample_tick),
        .o_in_stall    (o_in_stall),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    // datapath
    aso_dp #(
        .MAX_HARMONICS    (MAX_HARMONICS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_phase_step     (r_phase_step),
        .i_amplitude      (r_amplitude),
        .i_harmonic_count (r_harmonic_count),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_sample         (o_sample)
    );

endmodule

/* design/aso_ctrl.sv */
// Sequencer for the oscillator: input handshake and per-sample command schedule.
// Depends on aso_pkg (states, command and status structs).
`timescale 1ns / 1ps
`include "additive_sawtooth_oscillator_assert.svh"

module aso_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_sample_tick,
    output logic          o_in_stall,
    input  aso_pkg::t_sts i_sts,
    output aso_pkg::t_cmd o_cmd
);
    import aso_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sample_tick) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                o_cmd.load = 1'b1;
                n_state    = S_ROM;
            end
            S_ROM: begin
                o_cmd.rom = 1'b1;
                n_state   = S_RUN;
            end
            S_RUN: begin
                if (i_sts.left_zero) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_PART;
            end
            S_PART: begin
                o_cmd.part = 1'b1;
                n_state    = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_PUT;
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a new word is taken only between samples
    assign o_in_stall = (r_state != S_IDLE);

    // drain is only entered once every harmonic has been issued
    `ASO_ASSERT_IMPLIES(a_drain_after_run, i_clk, i_rst_n, r_state == S_DRAIN, i_sts.left_zero)

endmodule

/* design/aso_dp.sv */
// Datapath of the oscillator: phase accumulator, sine and weight tables,
// rotation recurrence, harmonic accumulator, output scaling and output register.
// Depends on aso_pkg (types, constants, table functions).
`timescale 1ns / 1ps
`include "additive_sawtooth_oscillator_assert.svh"

module aso_dp #(
    parameter int MAX_HARMONICS    = 512,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aso_pkg::t_cmd                       i_cmd,
    output aso_pkg::t_sts                       o_sts,
    input  logic [aso_pkg::PHASE_W-1:0]         i_phase_step,
    input  logic [aso_pkg::AMP_W-1:0]           i_amplitude,
    input  logic [aso_pkg::HC_W-1:0]            i_harmonic_count,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [aso_pkg::OUT_W-1:0]    o_sample
);
    import aso_pkg::*;

    localparam int IdxW   = $clog2(SINE_TABLE_DEPTH);
    localparam int WIdxW  = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int WgtW   = 21;
    localparam int TermW  = ROT_W + WgtW + 1;
    localparam int AccW   = TermW + $clog2(MAX_HARMONICS + 1);
    localparam int SumW   = AccW - 19;
    localparam int XW     = SumW + 24;
    localparam int LoW    = XW / 2;
    localparam int HiW    = XW - LoW;
    localparam int ProdW  = XW + AMP_W + 1;
    localparam int ShiftN = 57 - SAMPLE_BITS;

    localparam logic signed [AccW:0]  AccHalf = (AccW + 1)'(64'sd524288);
    localparam logic signed [ProdW:0] RndHalf = (ProdW + 1)'(64'sd1 <<< (ShiftN - 1));
    localparam logic signed [ProdW:0] SmpMax  =
        (ProdW + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ProdW:0] SmpMin  = -SmpMax - (ProdW + 1)'(1);

    // constant tables: sine/cosine per table phase, harmonic weights round(2^20/k)
    t_rot            w_sin_tab [SINE_TABLE_DEPTH];
    t_rot            w_cos_tab [SINE_TABLE_DEPTH];
    logic [WgtW-1:0] w_wgt_tab [MAX_HARMONICS];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
        localparam logic [31:0] RomPhase = 32'((64'(g) << 32) / SINE_TABLE_DEPTH);
        localparam t_rot        SinVal   = sine_q17(RomPhase);
        localparam t_rot        CosVal   = sine_q17(RomPhase + 32'h4000_0000);
        assign w_sin_tab[g] = SinVal;
        assign w_cos_tab[g] = CosVal;
    end

    for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_wgt
        localparam logic [WgtW-1:0] WgtVal =
            WgtW'(((64'd1 << 20) + 64'(g + 1) / 64'd2) / 64'(g + 1));
        assign w_wgt_tab[g] = WgtVal;
    end

    // control registers
    logic [PHASE_W-1:0] r_phase;
    logic [HC_W-1:0]    r_left;
    logic [WIdxW-1:0]   r_widx;
    logic               r_v1;
    logic               r_v2;
    logic               r_out_valid;

    // payload registers
    logic [IdxW-1:0]           r_idx;
    t_rot                      r_s1;
    t_rot                      r_c1;
    t_rot                      r_s;
    t_rot                      r_c;
    logic [WgtW-1:0]           r_w;
    logic signed [TermW-1:0]   r_term;
    logic signed [AccW-1:0]    r_acc;
    logic signed [SumW-1:0]    r_sum17;
    logic signed [XW-1:0]      r_x;
    logic [LoW+AMP_W-1:0]      r_plo;
    logic signed [HiW+AMP_W:0] r_phi;
    logic signed [ProdW-1:0]   r_prod;
    logic [OUT_W-1:0]          r_res;
    logic [OUT_W-1:0]          r_sample;

    // combinational helpers
    logic [32+IdxW:0]          w_idx_prod;
    logic [HC_W-1:0]           w_count;
    logic signed [2*ROT_W-1:0] w_p_sc;
    logic signed [2*ROT_W-1:0] w_p_cs;
    logic signed [2*ROT_W-1:0] w_p_cc;
    logic signed [2*ROT_W-1:0] w_p_ss;
    logic signed [2*ROT_W:0]   w_ns_sum;
    logic signed [2*ROT_W:0]   w_nc_sum;
    logic signed [AccW:0]      w_acc_sum;
    logic signed [AccW:0]      w_sum_rnd;
    logic signed [ProdW:0]     w_prod_sum;
    logic signed [ProdW:0]     w_rnd;
    logic signed [ProdW:0]     w_sat;

    // table index of the current phase
    assign w_idx_prod = r_phase * (IdxW + 1)'(SINE_TABLE_DEPTH);

    // harmonic count limited to the table size
    always_comb begin
        if (32'(i_harmonic_count) > 32'(MAX_HARMONICS)) begin
            w_count = HC_W'(MAX_HARMONICS);
        end else begin
            w_count = i_harmonic_count;
        end
    end

    // rotation by the base angle
    assign w_p_sc   = r_s * r_c1;
    assign w_p_cs   = r_c * r_s1;
    assign w_p_cc   = r_c * r_c1;
    assign w_p_ss   = r_s * r_s1;
    assign w_ns_sum = (2*ROT_W+1)'(w_p_sc) + (2*ROT_W+1)'(w_p_cs);
    assign w_nc_sum = (2*ROT_W+1)'(w_p_cc) - (2*ROT_W+1)'(w_p_ss);

    // accumulator rounded from q37 to q17
    assign w_acc_sum = (AccW + 1)'(r_acc) + AccHalf;
    assign w_sum_rnd = w_acc_sum >>> 20;

    // final rounding and saturation to the sample width
    assign w_prod_sum = (ProdW + 1)'(r_prod) + RndHalf;
    assign w_rnd      = w_prod_sum >>> ShiftN;

    always_comb begin
        priority if (w_rnd > SmpMax) begin
            w_sat = SmpMax;
        end else if (w_rnd < SmpMin) begin
            w_sat = SmpMin;
        end else begin
            w_sat = w_rnd;
        end
    end

    // phase, harmonic counters, pipeline valids, output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_left      <= '0;
            r_widx      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
            if (i_cmd.load) begin
                r_phase <= r_phase + i_phase_step;
                r_left  <= w_count;
            end
            if (i_cmd.rom) begin
                r_widx <= '0;
            end else if (i_cmd.step) begin
                r_widx <= r_widx + WIdxW'(1);
                r_left <= r_left - HC_W'(1);
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= w_idx_prod[32 +: IdxW];
        end
        if (i_cmd.rom) begin
            r_s1  <= w_sin_tab[r_idx];
            r_c1  <= w_cos_tab[r_idx];
            r_s   <= '0;
            r_c   <= ROT_ONE;
            r_acc <= '0;
        end else if (i_cmd.step) begin
            r_s <= rot_round_sat(w_ns_sum);
            r_c <= rot_round_sat(w_nc_sum);
            r_w <= w_wgt_tab[r_widx];
        end
        if (r_v1) begin
            r_term <= r_s * $signed({1'b0, r_w});
        end
        if (r_v2) begin
            r_acc <= r_acc + AccW'(r_term);
        end
        if (i_cmd.round) begin
            r_sum17 <= w_sum_rnd[SumW-1:0];
        end
        if (i_cmd.scale) begin
            r_x <= r_sum17 * INV_PI_Q24;
        end
        if (i_cmd.part) begin
            r_plo <= r_x[LoW-1:0] * i_amplitude;
            r_phi <= $signed(r_x[XW-1:LoW]) * $signed({1'b0, i_amplitude});
        end
        if (i_cmd.merge) begin
            r_prod <= (ProdW'(r_phi) <<< LoW) + ProdW'(r_plo);
        end
        if (i_cmd.sat) begin
            r_res <= w_sat[OUT_W-1:0];
        end
        if (i_cmd.put) begin
            r_sample <= r_res;
        end
    end

    // status back to the sequencer
    assign o_sts.left_zero  = (r_left == '0);
    assign o_sts.pipe_empty = !r_v1 && !r_v2;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // a harmonic step is only issued while harmonics remain
    `ASO_ASSERT_IMPLIES(a_step_has_work, i_clk, i_rst_n, i_cmd.step, r_left != '0)
    // a finished sample never overwrites one still waiting
    `ASO_ASSERT_IMPLIES(a_put_has_room, i_clk, i_rst_n, i_cmd.put, !r_out_valid || !i_out_stall)
    // rotated sine stays within plus or minus one
    `ASO_ASSERT_IMPLIES(a_rot_in_range, i_clk, i_rst_n, r_v1, r_s <= ROT_ONE && r_s >= -ROT_ONE)

endmodule
